[src/lsfd_pkg.sv]
// Shared types, constants and a helper function for the line sensor frame decoder.
`timescale 1ns / 1ps

package lsfd_pkg;

    // Frame format
    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] DEFAULT_ID  = 8'h01;
    localparam int         FRAME_LEN   = 7;
    localparam int         IDX_W       = 3;

    // Sensor array and fixed-point format
    localparam int NUM_SENSORS = 10;
    localparam int FRAC_BITS   = 8;
    localparam int HALF        = NUM_SENSORS / 2;
    localparam int CNT_W       = $clog2(NUM_SENSORS + 1);
    localparam int MAG_W       = 8;                  // |weighted sum| bits
    localparam int WS_W        = MAG_W + 1;          // signed weighted sum
    localparam int DIVD_W      = MAG_W + FRAC_BITS;  // dividend bits
    localparam int RADIX_BITS  = 4;                  // quotient bits per cycle
    localparam int DIV_CYCLES  = DIVD_W / RADIX_BITS;
    localparam int STEP_W      = $clog2(DIV_CYCLES);

    // Port field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int BITS_W   = 10;
    localparam int COUNT_W  = 4;
    localparam int POS_W    = 12;
    localparam int OUT_W    = STATUS_W + BITS_W + COUNT_W + POS_W;
    localparam int OUT_PAD  = ((OUT_W + 7) / 8) * 8 - OUT_W;
    localparam int TDATA_W  = OUT_W + OUT_PAD;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_CSUM = 2'd1,
        ST_ID   = 2'd2
    } frame_status_t;

    // One completed frame handed from the front to the back
    typedef struct packed {
        frame_status_t            status;
        logic [NUM_SENSORS-1:0]   pattern;
    } frame_rec_t;

    // Weight of sensor i: -HALF..-1 for the low half, 1..HALF for the high half
    function automatic logic signed [WS_W-1:0] sensor_weight(input int i);
        int w;
        w = (i < HALF) ? (i - HALF) : (i - HALF + 1);
        return WS_W'(w);
    endfunction

endpackage

[src/line_sensor_frame_decoder.sv]
// Each frame's record is queued with its checksum byte; the back end takes one frame
// at a time, runs a radix-16 divide by the lit count and loads the result into the
// output register. The input takes one byte per cycle while the queue is not full.
// A frame record queue of QUEUE_DEPTH entries lets the input run while results wait.
// Reset (rst_n, asynchronous, active low) returns to header hunt, empties the
// queue and the output register, and sets expected_id to 1.
`timescale 1ns / 1ps

module line_sensor_frame_decoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration: expected_id
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsfd_pkg::BYTE_W-1:0]       cfg_data,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lsfd_pkg::BYTE_W-1:0]       s_tdata,  // [7:0] rx_byte
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] frame_status, [11:2] sensor_bits, [15:12] lit_count,
    // [27:16] line_position, [31:28] zero
    output logic [lsfd_pkg::TDATA_W-1:0]      m_tdata
);

    logic                   q_full;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_valid;
    lsfd_pkg::frame_rec_t   push_rec;
    lsfd_pkg::frame_rec_t   head_rec;

    lsfd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (push_rec)
    );

    lsfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_rec   (head_rec)
    );

    lsfd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rec    (head_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[src/lsfd_front.sv]
// Front end: header hunt, frame capture, checksum and ID check.
`timescale 1ns / 1ps

module lsfd_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsfd_pkg::BYTE_W-1:0]       cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lsfd_pkg::BYTE_W-1:0]       s_tdata,
    input  logic                              q_full,
    output logic                              q_push,
    output lsfd_pkg::frame_rec_t              q_rec
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_ONE     = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    phase_t                           phase_reg;
    logic [lsfd_pkg::IDX_W-1:0]       idx_reg;
    logic [7:0]                       sum_reg;
    logic [7:0]                       id_reg;
    logic [7:0]                       b3_reg;
    logic [7:0]                       b4_reg;
    logic [7:0]                       b5_reg;
    logic [7:0]                       expected_id_reg;
    logic                             accept;
    logic                             last_byte;
    logic [15:0]                      full_pattern;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign last_byte = (phase_reg == PH_COLLECT) &&
                       (idx_reg == lsfd_pkg::IDX_W'(lsfd_pkg::FRAME_LEN - 1));

    // Frame record built from the stored bytes and the checksum byte now arriving
    assign full_pattern = {8'h00, b5_reg} | {4'h0, b4_reg, 4'h0} | {b3_reg, 8'h00};

    always_comb
    begin
        q_push = accept && last_byte;
        if (sum_reg != s_tdata)
        begin
            q_rec.status  = lsfd_pkg::ST_CSUM;
            q_rec.pattern = '0;
        end
        else if (id_reg != expected_id_reg)
        begin
            q_rec.status  = lsfd_pkg::ST_ID;
            q_rec.pattern = '0;
        end
        else
        begin
            q_rec.status  = lsfd_pkg::ST_OK;
            q_rec.pattern = full_pattern[lsfd_pkg::NUM_SENSORS-1:0];
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_id_reg <= lsfd_pkg::DEFAULT_ID;
        else if (cfg_valid && cfg_ready)
            expected_id_reg <= cfg_data;
    end

    // Sync state machine and byte capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (s_tdata == lsfd_pkg::HEADER_BYTE)
                        phase_reg <= PH_ONE;
                end
                PH_ONE:
                begin
                    if (s_tdata == lsfd_pkg::HEADER_BYTE)
                    begin
                        phase_reg <= PH_COLLECT;
                        idx_reg   <= '0;
                    end
                    else
                        phase_reg <= PH_HUNT;
                end
                PH_COLLECT:
                begin
                    unique case (idx_reg)
                        3'd0:
                        begin
                            id_reg  <= s_tdata;
                            sum_reg <= s_tdata;
                        end
                        3'd3:
                        begin
                            b3_reg  <= s_tdata;
                            sum_reg <= sum_reg + s_tdata;
                        end
                        3'd4:
                        begin
                            b4_reg  <= s_tdata;
                            sum_reg <= sum_reg + s_tdata;
                        end
                        3'd5:
                        begin
                            b5_reg  <= s_tdata;
                            sum_reg <= sum_reg + s_tdata;
                        end
                        default:
                        begin
                            sum_reg <= sum_reg + s_tdata;
                        end
                    endcase
                    if (last_byte)
                    begin
                        phase_reg <= PH_HUNT;
                        idx_reg   <= '0;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                default:
                begin
                    phase_reg <= PH_HUNT;
                end
            endcase
        end
    end

endmodule

[src/lsfd_queue.sv]
// Small register FIFO of frame records between the front and the back.
`timescale 1ns / 1ps

module lsfd_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lsfd_pkg::frame_rec_t  push_rec,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output lsfd_pkg::frame_rec_t  head_rec
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    lsfd_pkg::frame_rec_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [FILL_W-1:0]     fill_reg;

    assign full       = (fill_reg == FILL_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_rec   = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

[src/lsfd_back.sv]
// Back end: lit count, weighted sum and centroid divide, with output register.
`timescale 1ns / 1ps

module lsfd_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  lsfd_pkg::frame_rec_t                q_rec,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lsfd_pkg::TDATA_W-1:0]        m_tdata
);

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_DIV  = 2'd1,
        B_DONE = 2'd2
    } bstate_t;

    bstate_t                                state_reg;
    lsfd_pkg::frame_status_t                status_reg;
    logic [lsfd_pkg::NUM_SENSORS-1:0]       pattern_reg;
    logic [lsfd_pkg::CNT_W-1:0]             cnt_reg;
    logic                                   neg_reg;
    logic [lsfd_pkg::DIVD_W-1:0]            quo_reg;
    logic [lsfd_pkg::CNT_W-1:0]             rem_reg;
    logic [lsfd_pkg::STEP_W-1:0]            step_reg;
    logic                                   out_valid_reg;
    logic [lsfd_pkg::OUT_W-1:0]             out_data_reg;

    logic [lsfd_pkg::CNT_W-1:0]             cnt_c;
    logic signed [lsfd_pkg::WS_W-1:0]       wsum_c;
    logic [lsfd_pkg::WS_W-1:0]              wabs_c;
    logic [lsfd_pkg::DIVD_W-1:0]            quo_next;
    logic [lsfd_pkg::CNT_W-1:0]             rem_next;
    logic [lsfd_pkg::DIVD_W-1:0]            pos_mag;
    logic [lsfd_pkg::POS_W-1:0]             pos_c;

    assign q_pop    = (state_reg == B_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{lsfd_pkg::OUT_PAD{1'b0}}, out_data_reg};

    // Lit count and weighted sum of the queue head
    always_comb
    begin
        cnt_c  = '0;
        wsum_c = '0;
        for (int i = 0; i < lsfd_pkg::NUM_SENSORS; i++)
        begin
            if (q_rec.pattern[i])
            begin
                cnt_c  = cnt_c + 1'b1;
                wsum_c = wsum_c + lsfd_pkg::sensor_weight(i);
            end
        end
        wabs_c = wsum_c[lsfd_pkg::WS_W-1] ? -wsum_c : wsum_c;
    end

    // Restoring divide, RADIX_BITS quotient bits per cycle
    always_comb
    begin
        logic [lsfd_pkg::CNT_W:0] trial;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int k = 0; k < lsfd_pkg::RADIX_BITS; k++)
        begin
            trial    = {rem_next, quo_next[lsfd_pkg::DIVD_W-1]};
            quo_next = {quo_next[lsfd_pkg::DIVD_W-2:0], 1'b0};
            if (trial >= {1'b0, cnt_reg})
            begin
                trial       = trial - {1'b0, cnt_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[lsfd_pkg::CNT_W-1:0];
        end
    end

    // Sign fix-up; no lit sensor gives zero
    always_comb
    begin
        pos_mag = (cnt_reg == '0) ? '0 : quo_reg;
        pos_c   = neg_reg ? lsfd_pkg::POS_W'(-pos_mag) : lsfd_pkg::POS_W'(pos_mag);
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            // Result leaves on transfer unless B_DONE loads the next one
            if (out_valid_reg && m_tready && (state_reg != B_DONE))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        status_reg  <= q_rec.status;
                        pattern_reg <= q_rec.pattern;
                        cnt_reg     <= cnt_c;
                        neg_reg     <= wsum_c[lsfd_pkg::WS_W-1];
                        quo_reg     <= {wabs_c[lsfd_pkg::MAG_W-1:0],
                                        {lsfd_pkg::FRAC_BITS{1'b0}}};
                        rem_reg     <= '0;
                        step_reg    <= lsfd_pkg::STEP_W'(lsfd_pkg::DIV_CYCLES - 1);
                        state_reg   <= B_DIV;
                    end
                end
                B_DIV:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    if (step_reg == '0)
                        state_reg <= B_DONE;
                    else
                        step_reg <= step_reg - 1'b1;
                end
                B_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_data_reg  <= {pos_c,
                                          lsfd_pkg::COUNT_W'(cnt_reg),
                                          lsfd_pkg::BITS_W'(pattern_reg),
                                          status_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule
